FILE: rtl/cmrf_pkg.sv
// shared types and constants for the clap mode rgb fader
package cmrf_pkg;

    localparam int unsigned COLOR_MAX_DEF = 255;

    localparam int unsigned HOLD_W = 16;
    localparam int unsigned STEP_W = 8;
    localparam int unsigned LEVEL_W = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [HOLD_W-1:0] HOLD_MS_RESET = 16'd500;
    localparam logic [STEP_W-1:0] STEP_MS_RESET = 8'd10;
    localparam logic [HOLD_W-1:0] QUIET_MAX = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'hFF;

    typedef enum logic [0:0] {
        REG_HOLD_MS = 1'b0,
        REG_STEP_MS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_CYCLE  = 2'd1,
        MODE_FROZEN = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PHASE_RED   = 2'd0,
        PHASE_GREEN = 2'd1,
        PHASE_BLUE  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [HOLD_W-1:0] hold_ms;
        logic [STEP_W-1:0] step_ms;
    } cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [1:0]         lamp_mode;
        logic               clap_seen;
    } result_t;

endpackage

FILE: rtl/cmrf_core.sv
// clap detector, mode sequencer and color wheel state with per-tick update
module cmrf_core #(
    parameter int unsigned COLOR_MAX = cmrf_pkg::COLOR_MAX_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             sound,
    input  cmrf_pkg::cfg_t   cfg,
    output cmrf_pkg::result_t result
);

    localparam int unsigned CW = $clog2(COLOR_MAX + 1);
    localparam logic [CW-1:0] CMAX = CW'(COLOR_MAX);

    logic                           armed_reg, armed_next;
    logic [cmrf_pkg::HOLD_W-1:0]    quiet_reg, quiet_next;
    cmrf_pkg::mode_t                mode_reg, mode_next;
    logic [1:0]                     phase_reg, phase_next;
    logic [CW-1:0]                  units_reg, units_next;
    logic [cmrf_pkg::STEP_W-1:0]    wait_reg, wait_next;
    logic [CW-1:0]                  col_reg [3];
    logic [CW-1:0]                  col_next [3];

    logic                           clap;
    logic [cmrf_pkg::STEP_W-1:0]    period;
    logic [cmrf_pkg::STEP_W-1:0]    wait_inc;
    logic [CW-1:0]                  units_inc;
    logic [1:0]                     ph;
    logic [1:0]                     ph_inc;
    logic [cmrf_pkg::LEVEL_W-1:0]   level [3];

    // clap detection
    always_comb
    begin
        armed_next = armed_reg;
        quiet_next = quiet_reg;
        mode_next  = mode_reg;
        clap       = 1'b0;
        if (sound)
        begin
            quiet_next = '0;
            if (!armed_reg)
            begin
                armed_next = 1'b1;
                clap       = 1'b1;
                case (mode_reg)
                    cmrf_pkg::MODE_OFF:   mode_next = cmrf_pkg::MODE_CYCLE;
                    cmrf_pkg::MODE_CYCLE: mode_next = cmrf_pkg::MODE_FROZEN;
                    default:              mode_next = cmrf_pkg::MODE_OFF;
                endcase
            end
        end
        else
        begin
            if (quiet_reg != cmrf_pkg::QUIET_MAX)
            begin
                quiet_next = quiet_reg + 16'd1;
            end
            if (armed_reg && (quiet_next > cfg.hold_ms))
            begin
                armed_next = 1'b0;
            end
        end
    end

    // color wheel
    always_comb
    begin
        period    = (cfg.step_ms == '0) ? 8'd1 : cfg.step_ms;
        wait_inc  = wait_reg + 8'd1;
        units_inc = units_reg + CW'(1);
        ph        = (phase_reg > cmrf_pkg::PHASE_BLUE) ? cmrf_pkg::PHASE_RED : phase_reg;
        ph_inc    = (ph == cmrf_pkg::PHASE_BLUE) ? cmrf_pkg::PHASE_RED : ph + 2'd1;

        phase_next = phase_reg;
        units_next = units_reg;
        wait_next  = wait_reg;
        for (int i = 0; i < 3; i++)
        begin
            col_next[i] = col_reg[i];
        end

        if (mode_next == cmrf_pkg::MODE_CYCLE)
        begin
            if (clap)
            begin
                col_next[0] = CMAX;
                col_next[1] = '0;
                col_next[2] = '0;
                phase_next  = cmrf_pkg::PHASE_RED;
                units_next  = '0;
                wait_next   = '0;
            end
            else if (wait_inc >= period)
            begin
                wait_next = '0;
                for (int i = 0; i < 3; i++)
                begin
                    if (ph == 2'(i))
                    begin
                        if (col_reg[i] != '0)
                        begin
                            col_next[i] = col_reg[i] - CW'(1);
                        end
                    end
                    else if (ph_inc == 2'(i))
                    begin
                        if (col_reg[i] < CMAX)
                        begin
                            col_next[i] = col_reg[i] + CW'(1);
                        end
                    end
                end
                if (units_inc >= CMAX)
                begin
                    units_next = '0;
                    phase_next = ph_inc;
                end
                else
                begin
                    units_next = units_inc;
                    phase_next = ph;
                end
            end
            else
            begin
                wait_next = wait_inc;
            end
        end
    end

    // result
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (32'(col_next[i]) > 32'(cmrf_pkg::LEVEL_MAX))
            begin
                level[i] = cmrf_pkg::LEVEL_MAX;
            end
            else
            begin
                level[i] = cmrf_pkg::LEVEL_W'(col_next[i]);
            end
        end
        if (mode_next == cmrf_pkg::MODE_CYCLE || mode_next == cmrf_pkg::MODE_FROZEN)
        begin
            result.red_level   = level[0];
            result.green_level = level[1];
            result.blue_level  = level[2];
        end
        else
        begin
            result.red_level   = '0;
            result.green_level = '0;
            result.blue_level  = '0;
        end
        result.lamp_mode = mode_next;
        result.clap_seen = clap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            quiet_reg <= '0;
            mode_reg  <= cmrf_pkg::MODE_OFF;
            phase_reg <= cmrf_pkg::PHASE_RED;
            units_reg <= '0;
            wait_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                col_reg[i] <= '0;
            end
        end
        else if (step_en)
        begin
            armed_reg <= armed_next;
            quiet_reg <= quiet_next;
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            units_reg <= units_next;
            wait_reg  <= wait_next;
            for (int i = 0; i < 3; i++)
            begin
                col_reg[i] <= col_next[i];
            end
        end
    end

endmodule

FILE: rtl/clap_mode_rgb_fader.sv
// top level of the clap mode rgb fader: handshake, config registers, result register
//
// channel  dir  handshake                      payload
// in       in   in_valid / in_stall            sound_present
// out      out  out_valid / out_stall          red_level green_level blue_level
//                                              lamp_mode clap_seen
// cfg      in   cfg_write                      cfg_index cfg_data
//
// one transaction per cycle sustained while out_stall is low; path: input register, then result register
// the whole tick update sits between the input register and the result register
// reset: hold_ms 500, step_ms 10, detector disarmed, lamp off, color black
// out_stall holds the result register; in_stall rises in the same cycle when both are full
module clap_mode_rgb_fader #(
    parameter int unsigned COLOR_MAX = cmrf_pkg::COLOR_MAX_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              sound_present,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [cmrf_pkg::LEVEL_W-1:0]      red_level,
    output logic [cmrf_pkg::LEVEL_W-1:0]      green_level,
    output logic [cmrf_pkg::LEVEL_W-1:0]      blue_level,
    output logic [1:0]                        lamp_mode,
    output logic                              clap_seen,
    input  logic                              cfg_write,
    input  logic                              cfg_index,
    input  logic [cmrf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    cmrf_pkg::cfg_t     cfg_reg, cfg_next;
    logic               in_vld_reg, in_vld_next;
    logic               sound_reg;
    logic               out_vld_reg, out_vld_next;
    cmrf_pkg::result_t  result_reg;
    cmrf_pkg::result_t  core_result;
    logic               advance;
    logic               in_accept;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cmrf_pkg::cfg_index_t'(cfg_index))
                cmrf_pkg::REG_HOLD_MS: cfg_next.hold_ms = cfg_data;
                cmrf_pkg::REG_STEP_MS: cfg_next.step_ms = cfg_data[cmrf_pkg::STEP_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_accept)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_ms <= cmrf_pkg::HOLD_MS_RESET;
            cfg_reg.step_ms <= cmrf_pkg::STEP_MS_RESET;
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
        end
        else
        begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sound_reg <= sound_present;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    cmrf_core #(
        .COLOR_MAX (COLOR_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .sound   (sound_reg),
        .cfg     (cfg_reg),
        .result  (core_result)
    );

    assign out_valid   = out_vld_reg;
    assign red_level   = result_reg.red_level;
    assign green_level = result_reg.green_level;
    assign blue_level  = result_reg.blue_level;
    assign lamp_mode   = result_reg.lamp_mode;
    assign clap_seen   = result_reg.clap_seen;

    // lamp off shows black
    a_off_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lamp_mode == cmrf_pkg::MODE_OFF) |->
            (red_level == '0) && (green_level == '0) && (blue_level == '0))
        else $error("lamp off with nonzero color");

    // entering cycling restarts at full red
    a_cycle_start: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clap_seen && (lamp_mode == cmrf_pkg::MODE_CYCLE) |->
            (red_level != '0) && (green_level == '0) && (blue_level == '0))
        else $error("cycling did not restart at red");

    // a tick that leaves the input register lands in the result register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("transaction lost between stages");

    // input stalls only while the input register is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a full pipeline");

endmodule
